@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GRI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gri: same-cycle check failed");

// next-cycle implication
`define GRI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gri: next-cycle check failed");

`endif

@@ rtl/core/gri_pkg.sv @@
// ----------------------------------------------------------------------------
// gri_pkg
// Types and GF(2) / ring helper functions for the Galois ring inverse.
// ----------------------------------------------------------------------------
package gri_pkg;

    localparam int unsigned MAX_BITS = 64;
    localparam int unsigned NUM_COEF = 3;

    typedef logic [MAX_BITS-1:0] coef_t;
    typedef coef_t [NUM_COEF-1:0] poly_t;
    typedef coef_t [4:0] wide_t;
    typedef logic [2:0] gf2_poly_t;

    typedef struct packed {
        logic      is_unit;
        gf2_poly_t inv_bits;
    } unit_info_t;

    function automatic coef_t sel_coef(logic s, coef_t v);
        return s ? v : '0;
    endfunction

    function automatic gf2_poly_t gf2_mul(gf2_poly_t a, gf2_poly_t c, gf2_poly_t f);
        logic [4:0] p;
        logic [3:0] fm;
        p  = '0;
        fm = {1'b1, f};
        for (int i = 0; i < 3; i++) begin
            if (c[i]) p = p ^ ({2'b00, a} << i);
        end
        if (p[4]) p = p ^ {fm, 1'b0};
        if (p[3]) p = p ^ {1'b0, fm};
        return p[2:0];
    endfunction

    function automatic gf2_poly_t gf2_inv(gf2_poly_t g, gf2_poly_t f);
        gf2_poly_t b;
        b = '0;
        for (int c = 7; c >= 1; c--) begin
            if (gf2_mul(g, 3'(c), f) == 3'd1) b = 3'(c);
        end
        return b;
    endfunction

    // x^3 = -(f2 x^2 + f1 x + f0)
    function automatic poly_t ring_reduce(wide_t p_in, gf2_poly_t f);
        wide_t p;
        poly_t r;
        p    = p_in;
        p[3] = p[3] - sel_coef(f[2], p[4]);
        p[2] = p[2] - sel_coef(f[1], p[4]);
        p[1] = p[1] - sel_coef(f[0], p[4]);
        p[2] = p[2] - sel_coef(f[2], p[3]);
        p[1] = p[1] - sel_coef(f[1], p[3]);
        p[0] = p[0] - sel_coef(f[0], p[3]);
        r[0] = p[0];
        r[1] = p[1];
        r[2] = p[2];
        return r;
    endfunction

    // product with a polynomial of 0/1 coefficients
    function automatic poly_t ring_mul_bits(gf2_poly_t b, poly_t a, gf2_poly_t f);
        wide_t p;
        p = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p[i+j] = p[i+j] + sel_coef(b[i], a[j]);
            end
        end
        return ring_reduce(p, f);
    endfunction

endpackage

@@ rtl/core/gri_ring_mul.sv @@
// ----------------------------------------------------------------------------
// gri_ring_mul
// Three-stage pipelined a*c + d in Z mod 2^W [x]/(f): half-width partial
// products, convolution, reduction and add. Sideband bits travel along.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gri_ring_mul import gri_pkg::*; #(
    parameter int W  = 64,
    parameter int SB = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gf2_poly_t           f,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0][W-1:0]   a,
    input  logic [2:0][W-1:0]   c,
    input  logic [2:0][W-1:0]   d,
    input  logic [SB-1:0]       in_side,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0][W-1:0]   out_p,
    output logic [SB-1:0]       out_side
);

    localparam int H = (W + 1) / 2;
    localparam int L = W - H;

    logic             v1_reg, v2_reg, v3_reg;
    logic             en1, en2, en3;

    logic [W-1:0]     ll_next [3][3];
    logic [L-1:0]     cr_next [3][3];
    logic [W-1:0]     ll_reg  [3][3];
    logic [L-1:0]     cr_reg  [3][3];
    logic [2:0][W-1:0] d1_reg, d2_reg;
    logic [SB-1:0]    side1_reg, side2_reg, side3_reg;

    logic [4:0][W-1:0] p_next, p_reg;
    logic [2:0][W-1:0] r_next, r_reg;
    wide_t             p_wide;
    poly_t             p_red;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            logic [2*H-1:0] ll_full;
            logic [W-1:0]   lh_full;
            logic [W-1:0]   hl_full;
            assign ll_full = a[i][H-1:0] * c[j][H-1:0];
            assign lh_full = a[i][H-1:0] * c[j][W-1:H];
            assign hl_full = a[i][W-1:H] * c[j][H-1:0];
            assign ll_next[i][j] = ll_full[W-1:0];
            assign cr_next[i][j] = lh_full[L-1:0] + hl_full[L-1:0];
        end
    end

    always_comb begin
        p_next = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p_next[i+j] = p_next[i+j] + ll_reg[i][j] + {cr_reg[i][j], {H{1'b0}}};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 5; k++) p_wide[k] = coef_t'(p_reg[k]);
        p_red = ring_reduce(p_wide, f);
        for (int k = 0; k < 3; k++) r_next[k] = p_red[k][W-1:0] + d2_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            ll_reg    <= ll_next;
            cr_reg    <= cr_next;
            d1_reg    <= d;
            side1_reg <= in_side;
        end
        if (en2) begin
            p_reg     <= p_next;
            d2_reg    <= d1_reg;
            side2_reg <= side1_reg;
        end
        if (en3) begin
            r_reg     <= r_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_p     = r_reg;
    assign out_side  = side3_reg;

    `GRI_ASSERT_NOW(a_full_when_blocked, !in_ready, v1_reg && v2_reg && v3_reg && !out_ready)
    `GRI_ASSERT_NEXT(a_bubble_fills, v1_reg && !v2_reg, v2_reg)
    `GRI_ASSERT_NEXT(a_last_advances, v2_reg && en3, v3_reg)

endmodule

@@ rtl/core/gri_front.sv @@
// ----------------------------------------------------------------------------
// gri_front
// Input stage: GF(2) inverse b of g mod 2 and u = 1 - b*g in the ring.
// ----------------------------------------------------------------------------
module gri_front import gri_pkg::*; #(
    parameter int W = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gf2_poly_t          f,
    input  logic               in_valid,
    output logic               in_ready,
    input  poly_t              coef,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0][W-1:0]  out_u,
    output unit_info_t         out_info
);

    logic              v_reg;
    logic              en;
    poly_t             g_ext;
    gf2_poly_t         g2;
    gf2_poly_t         b;
    poly_t             t;
    logic [2:0][W-1:0] u_next, u_reg;
    unit_info_t        info_next, info_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        for (int k = 0; k < 3; k++) g_ext[k] = coef_t'(coef[k][W-1:0]);
        g2 = {coef[2][0], coef[1][0], coef[0][0]};
        b  = gf2_inv(g2, f);
        t  = ring_mul_bits(b, g_ext, f);
        u_next[0] = W'(1) - t[0][W-1:0];
        u_next[1] = W'(0) - t[1][W-1:0];
        u_next[2] = W'(0) - t[2][W-1:0];
        info_next.is_unit  = (b != 3'd0);
        info_next.inv_bits = b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u_next;
            info_reg <= info_next;
        end
    end

    assign out_valid = v_reg;
    assign out_u     = u_reg;
    assign out_info  = info_reg;

endmodule

@@ rtl/core/gri_level.sv @@
// ----------------------------------------------------------------------------
// gri_level
// One bit of the series length: R += Q*S, Q *= P when the bit is set; S *= (1 + P),
// P *= P. Four ring multipliers in lockstep; the last level keeps only R's.
// ----------------------------------------------------------------------------
module gri_level import gri_pkg::*; #(
    parameter int W       = 64,
    parameter bit BIT_SET = 1'b1,
    parameter bit LAST    = 1'b0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gf2_poly_t          f,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0][W-1:0]  r_in,
    input  logic [2:0][W-1:0]  q_in,
    input  logic [2:0][W-1:0]  s_in,
    input  logic [2:0][W-1:0]  p_in,
    input  unit_info_t         info_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0][W-1:0]  r_out,
    output logic [2:0][W-1:0]  q_out,
    output logic [2:0][W-1:0]  s_out,
    output logic [2:0][W-1:0]  p_out,
    output unit_info_t         info_out
);

    localparam logic [2:0][W-1:0] ONE_POLY  = {{W{1'b0}}, {W{1'b0}}, W'(1)};
    localparam logic [2:0][W-1:0] ZERO_POLY = '0;

    logic [2:0][W-1:0] r_a;

    assign r_a = BIT_SET ? q_in : ZERO_POLY;

    gri_ring_mul #(.W(W), .SB($bits(unit_info_t))) u_mul_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .f         (f),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a         (r_a),
        .c         (s_in),
        .d         (r_in),
        .in_side   (info_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_p     (r_out),
        .out_side  (info_out)
    );

    if (!LAST) begin : g_next
        logic [2:0][W-1:0] q_c;
        assign q_c = BIT_SET ? p_in : ONE_POLY;

        gri_ring_mul #(.W(W), .SB(1)) u_mul_q (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .f         (f),
            .in_valid  (in_valid),
            .in_ready  (),
            .a         (q_in),
            .c         (q_c),
            .d         (ZERO_POLY),
            .in_side   (1'b0),
            .out_valid (),
            .out_ready (out_ready),
            .out_p     (q_out),
            .out_side  ()
        );

        gri_ring_mul #(.W(W), .SB(1)) u_mul_s (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .f         (f),
            .in_valid  (in_valid),
            .in_ready  (),
            .a         (s_in),
            .c         (p_in),
            .d         (s_in),
            .in_side   (1'b0),
            .out_valid (),
            .out_ready (out_ready),
            .out_p     (s_out),
            .out_side  ()
        );

        gri_ring_mul #(.W(W), .SB(1)) u_mul_p (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .f         (f),
            .in_valid  (in_valid),
            .in_ready  (),
            .a         (p_in),
            .c         (p_in),
            .d         (ZERO_POLY),
            .in_side   (1'b0),
            .out_valid (),
            .out_ready (out_ready),
            .out_p     (p_out),
            .out_side  ()
        );
    end else begin : g_tail
        assign q_out = ZERO_POLY;
        assign s_out = ZERO_POLY;
        assign p_out = ZERO_POLY;
    end

endmodule

@@ rtl/core/gri_back.sv @@
// ----------------------------------------------------------------------------
// gri_back
// Output stage: inverse = b * R, zero for a non-unit; output register.
// ----------------------------------------------------------------------------
module gri_back import gri_pkg::*; #(
    parameter int W = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gf2_poly_t          f,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0][W-1:0]  r_in,
    input  unit_info_t         info_in,
    output logic               out_valid,
    input  logic               out_ready,
    output poly_t              out_inv,
    output logic               out_unit
);

    logic  v_reg;
    logic  en;
    poly_t r_ext;
    poly_t res;
    poly_t inv_next, inv_reg;
    logic  unit_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        for (int k = 0; k < 3; k++) r_ext[k] = coef_t'(r_in[k]);
        res = ring_mul_bits(info_in.inv_bits, r_ext, f);
        for (int k = 0; k < 3; k++) begin
            inv_next[k] = info_in.is_unit ? coef_t'(res[k][W-1:0]) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg  <= inv_next;
            unit_reg <= info_in.is_unit;
        end
    end

    assign out_valid = v_reg;
    assign out_inv   = inv_reg;
    assign out_unit  = unit_reg;

endmodule

@@ rtl/core/galois_ring_inverse.sv @@
// ----------------------------------------------------------------------------
// galois_ring_inverse
// Inverse in Z mod 2^COEF_BITS [x]/(f), f monic cubic, one word per cycle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: coef0, coef1, coef2
//  m_axis    out  tvalid/tready          tdata: inv0, inv1, inv2; tuser: is_unit
//  cfg       in   cfg_wr_en              cfg_wr_data: modulus_poly_low
//
//  Throughput one word per cycle while m_axis_tready is high; NLEV =
//  bits of min(SERIES_TERMS, COEF_BITS), one level of ring multipliers
//  (3 stages) per bit. Each stage holds its word on a stall and fills bubbles.
//  Reset clears valid bits and sets modulus_poly_low to 5.
// ----------------------------------------------------------------------------
module galois_ring_inverse import gri_pkg::*; #(
    parameter int COEF_BITS    = 64,
    parameter int SERIES_TERMS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_wr_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [191:0]  s_axis_tdata,   // coef0, coef1, coef2
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,   // inv0, inv1, inv2
    output logic          m_axis_tuser    // is_unit
);

    localparam int W    = COEF_BITS;
    localparam int NEFF = (SERIES_TERMS < COEF_BITS) ? SERIES_TERMS : COEF_BITS;
    localparam int NLEV = $clog2(NEFF + 1);

    localparam logic [2:0][W-1:0] ONE_POLY = {{W{1'b0}}, {W{1'b0}}, W'(1)};

    gf2_poly_t         modulus_poly_low_reg;
    poly_t             s_coef;
    poly_t             m_inv;

    logic              lv_valid [0:NLEV];
    logic              lv_ready [0:NLEV];
    logic [2:0][W-1:0] lv_r     [0:NLEV];
    logic [2:0][W-1:0] lv_q     [0:NLEV];
    logic [2:0][W-1:0] lv_s     [0:NLEV];
    logic [2:0][W-1:0] lv_p     [0:NLEV];
    unit_info_t        lv_info  [0:NLEV];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_poly_low_reg <= 3'd5;
        end else if (cfg_wr_en) begin
            modulus_poly_low_reg <= cfg_wr_data;
        end
    end

    assign s_coef = s_axis_tdata;

    gri_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .f         (modulus_poly_low_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .coef      (s_coef),
        .out_valid (lv_valid[0]),
        .out_ready (lv_ready[0]),
        .out_u     (lv_p[0]),
        .out_info  (lv_info[0])
    );

    assign lv_r[0] = '0;
    assign lv_q[0] = ONE_POLY;
    assign lv_s[0] = ONE_POLY;

    for (genvar k = 0; k < NLEV; k++) begin : g_lev
        gri_level #(
            .W       (W),
            .BIT_SET (((NEFF >> k) & 1) == 1),
            .LAST    (k == NLEV - 1)
        ) u_level (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .f         (modulus_poly_low_reg),
            .in_valid  (lv_valid[k]),
            .in_ready  (lv_ready[k]),
            .r_in      (lv_r[k]),
            .q_in      (lv_q[k]),
            .s_in      (lv_s[k]),
            .p_in      (lv_p[k]),
            .info_in   (lv_info[k]),
            .out_valid (lv_valid[k+1]),
            .out_ready (lv_ready[k+1]),
            .r_out     (lv_r[k+1]),
            .q_out     (lv_q[k+1]),
            .s_out     (lv_s[k+1]),
            .p_out     (lv_p[k+1]),
            .info_out  (lv_info[k+1])
        );
    end

    gri_back #(.W(W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .f         (modulus_poly_low_reg),
        .in_valid  (lv_valid[NLEV]),
        .in_ready  (lv_ready[NLEV]),
        .r_in      (lv_r[NLEV]),
        .info_in   (lv_info[NLEV]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_inv   (m_inv),
        .out_unit  (m_axis_tuser)
    );

    assign m_axis_tdata = m_inv;

endmodule

@@ bench/galois_ring_inverse_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galois_ring_inverse_chk
// Watches both streams, computes the ring inverse of every accepted word and
// compares it with the words leaving the block, in order.
// ----------------------------------------------------------------------------
module galois_ring_inverse_chk import gri_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           errors,
    output int           pending
);

    typedef struct {
        logic [63:0] c [3];
        logic        unit;
    } inverse_t;

    inverse_t    inverse_q[$];
    logic [2:0]  modulus;
    int          err_count = 0;

    // a * c mod f, coefficients mod 2^64
    function automatic void poly_mul(input logic [63:0] a [3], input logic [63:0] c [3],
                                     input logic [2:0] f, output logic [63:0] r [3]);
        logic [63:0] p [5];
        for (int i = 0; i < 5; i++) p[i] = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i+j] += a[i] * c[j];
        for (int k = 4; k >= 3; k--)
            for (int i = 0; i < 3; i++)
                if (f[i]) p[k-3+i] -= p[k];
        for (int i = 0; i < 3; i++) r[i] = p[i];
    endfunction

    function automatic inverse_t ring_inverse(logic [191:0] d, logic [2:0] f);
        inverse_t    res;
        logic [63:0] g [3], bv [3], t [3], negh [3], term [3], sum [3];
        logic [2:0]  g2, b;
        logic [4:0]  w;
        for (int i = 0; i < 3; i++) g[i] = d[64*i +: 64];
        g2 = {g[2][0], g[1][0], g[0][0]};
        b = '0;
        for (int cand = 7; cand >= 1; cand--) begin
            w = '0;
            for (int i = 0; i < 3; i++) if (cand[i]) w ^= {2'b00, g2} << i;
            if (w[4]) w ^= {1'b1, f, 1'b0};
            if (w[3]) w ^= {1'b0, 1'b1, f};
            if (w[2:0] == 3'd1) b = 3'(cand);
        end
        res.unit = (b != 0);
        for (int i = 0; i < 3; i++) res.c[i] = '0;
        if (b == 0) return res;
        for (int i = 0; i < 3; i++) bv[i] = {63'd0, b[i]};
        poly_mul(bv, g, f, t);
        negh[0] = 64'd1 - t[0];
        negh[1] = -t[1];
        negh[2] = -t[2];
        term[0] = 64'd1; term[1] = '0; term[2] = '0;
        for (int i = 0; i < 3; i++) sum[i] = '0;
        for (int n = 0; n < 64; n++) begin
            for (int i = 0; i < 3; i++) sum[i] += term[i];
            poly_mul(term, negh, f, t);
            term = t;
        end
        poly_mul(sum, bv, f, res.c);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    assign pending = inverse_q.size();
    assign errors  = err_count;

    always @(posedge aclk) begin
        inverse_t want;
        if (!aresetn) begin
            modulus <= 3'd5;
            inverse_q.delete();
        end else begin
            if (cfg_wr_en) modulus <= cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                inverse_q.push_back(ring_inverse(s_axis_tdata, modulus));
            if (m_axis_tvalid && m_axis_tready) begin
                if (inverse_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
                end else begin
                    want = inverse_q.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (m_axis_tdata[64*i +: 64] !== want.c[i])
                            report_mismatch($sformatf("inv%0d", i),
                                            m_axis_tdata[64*i +: 64], want.c[i]);
                    if (m_axis_tuser !== want.unit)
                        report_mismatch("is_unit", {63'd0, m_axis_tuser}, {63'd0, want.unit});
                end
            end
        end
    end

endmodule

@@ bench/galois_ring_inverse_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galois_ring_inverse_tb
// Bursty random and directed ring elements under every modulus, with a
// stalling receiver; the checker predicts each inverse and counts mismatches.
// ----------------------------------------------------------------------------
module galois_ring_inverse_tb;

    localparam int LATENCY = 23;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           errors;
    int           pending;

    galois_ring_inverse DUT (.*);

    galois_ring_inverse_chk checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [63:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1;
            3: return 64'h8000_0000_0000_0000;
            4: return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(logic [191:0] d);
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic gap(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    task automatic set_modulus(logic [2:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver stall pattern
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            mode = int'(($time / 20000) % 3);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    initial begin
        logic [2:0] mods [8] = '{3'd5, 3'd0, 3'd7, 3'd1, 3'd3, 3'd2, 3'd4, 3'd6};
        int burst;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every residue mod 2, extremes of coefficients
        for (int r = 0; r < 8; r++)
            send_word({64'(r[2]), 64'(r[1]), 64'(r[0])});
        send_word('1);
        send_word('0);
        send_word({64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF});
        send_word({{$urandom, $urandom}, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF});
        drain();

        for (int m = 0; m < 8; m++) begin
            set_modulus(mods[m]);
            for (int n = 0; n < 240;) begin
                burst = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 30);
                for (int k = 0; k < burst; k++, n++)
                    send_word({rand_coef(), rand_coef(), rand_coef()});
                if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
            end
            drain();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/gri_pkg.sv
rtl/core/gri_ring_mul.sv
rtl/core/gri_front.sv
rtl/core/gri_level.sv
rtl/core/gri_back.sv
rtl/core/galois_ring_inverse.sv
bench/galois_ring_inverse_chk.sv
bench/galois_ring_inverse_tb.sv
